@@ rtl/sync_frame_receiver_crc16_macros.svh @@
// Assertion macros used by the frame receiver RTL.
`ifndef SYNC_FRAME_RECEIVER_CRC16_MACROS_SVH
`define SYNC_FRAME_RECEIVER_CRC16_MACROS_SVH

// Concurrent check on the rising clock, ignored while reset is asserted.
`define SFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// Package with constants, phase codes and the CRC-16 step of the frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND = 8'h55;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  EXPECTED_VERSION_RESET    = 8'h03;
	localparam int          MAX_PAYLOAD_BYTES_DEFAULT = 64;

	typedef enum logic [3:0] {
		PH_HUNT     = 4'd0,
		PH_SYNC2    = 4'd1,
		PH_VERSION  = 4'd2,
		PH_MESSAGE  = 4'd3,
		PH_SEQUENCE = 4'd4,
		PH_LENGTH   = 4'd5,
		PH_PAYLOAD  = 4'd6,
		PH_CRC_LO   = 4'd7,
		PH_CRC_HI   = 4'd8
	} phase_t;

	// One byte of CRC-16, MSB first, no reflection.
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/sync_frame_receiver_crc16.sv @@
// Top level of the sync-header frame receiver with CRC-16 check.
//
// The rx channel takes one received byte per request (rx_valid, rx_stall).
// The block hunts for the sync pair AA 55, then reads version, message,
// sequence and length bytes, up to MAX_PAYLOAD_BYTES payload bytes, and a
// little-endian CRC-16 (poly 0x1021, init 0xFFFF). Payload bytes go into a
// small RAM as they arrive, while the CRC runs one byte per cycle whenever
// byte is taken. When the CRC high byte is taken, a good frame with the
// expected version produces max(1, length) result requests; any other
// complete frame produces one rejected result. A length above
// MAX_PAYLOAD_BYTES drops the frame quietly. The CRC high byte starts the
// readout, whose results are registered. Results leave at one per cycle
// while result_stall is low, paced by the single read port of the payload
// RAM, and rx_stall stays high until the last result of the frame has
// been issued, so no new bytes are taken during readout. When result_stall
// is high with a result valid, the result register holds and no further
// RAM read is issued. Reset puts the block in the sync hunt with
// expected_version at 3; the payload RAM needs no clearing, since only
// entries written by the current frame are ever read back.
`timescale 1ns / 1ps
`include "sync_frame_receiver_crc16_macros.svh"
module sync_frame_receiver_crc16
	import sfr_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	// received bytes
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	// results
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] message_type,
	output logic [7:0] sequence_number,
	output logic [6:0] payload_length,
	output logic       frame_status,
	output logic [7:0] payload_byte,
	output logic [5:0] byte_position,
	output logic       last_of_frame
);

	// Length values run from 0 to MAX_PAYLOAD_BYTES; RAM addresses below it.
	localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
	localparam logic [7:0]     MAX_B = 8'(MAX_PAYLOAD_BYTES);
	localparam logic [LEN_W:0] MAX_L = (LEN_W + 1)'(MAX_PAYLOAD_BYTES);

	// Per-byte control decoded from the phase.
	typedef struct packed {
		logic crc_init;
		logic crc_en;
		logic cap_version;
		logic cap_message;
		logic cap_sequence;
		logic cap_length;
		logic fill_clr;
		logic ram_we;
		logic cap_crc_lo;
		logic frame_done;
	} rx_ctl_t;

	phase_t            phase_q, phase_d;
	rx_ctl_t           ctl;
	logic              rx_take;
	logic [7:0]        expected_version_q;
	logic [7:0]        version_q, message_q, sequence_q, crc_lo_q;
	logic [LEN_W-1:0]  length_q, fill_q;
	logic [LEN_W:0]    fill_inc;
	logic [15:0]       crc_q;
	logic              len_over, fill_full, frame_good;

	logic              emit_active_q, emit_reject_q, emit_zero_q;
	logic [LEN_W-1:0]  emit_idx_q;
	logic [LEN_W:0]    emit_inc;
	logic              issue, issue_last;

	logic              res_valid_q, res_status_q, res_zero_q, res_last_q;
	logic [7:0]        res_msg_q, res_seq_q;
	logic [LEN_W-1:0]  res_len_q;
	logic [IDX_W-1:0]  res_pos_q;
	logic [7:0]        ram_rd_data;
	logic [7:0]        len_ext, pos_ext;

	// Input is held off while a frame's results are being read out of the RAM.
	assign rx_stall  = emit_active_q;
	assign rx_take   = rx_valid && !rx_stall;

	assign len_over  = rx_byte > MAX_B;
	assign fill_inc  = {1'b0, fill_q} + 1'b1;
	assign fill_full = {1'b0, fill_q} >= MAX_L;
	assign frame_good = ({rx_byte, crc_lo_q} == crc_q) && (version_q == expected_version_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= EXPECTED_VERSION_RESET;
		end else if (cfg_wr_en) begin
			expected_version_q <= cfg_wr_data;
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT:     phase_d = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d = PH_VERSION;
				end else begin
					phase_d = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
				end
			end
			PH_VERSION:  phase_d = PH_MESSAGE;
			PH_MESSAGE:  phase_d = PH_SEQUENCE;
			PH_SEQUENCE: phase_d = PH_LENGTH;
			PH_LENGTH: begin
				if (len_over) begin
					phase_d = PH_HUNT;
				end else begin
					phase_d = (rx_byte == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (fill_full || (fill_inc >= {1'b0, length_q})) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO:   phase_d = PH_CRC_HI;
			PH_CRC_HI:   phase_d = PH_HUNT;
			default:     phase_d = PH_HUNT;
		endcase
	end

	// Per-phase control.
	always_comb begin
		ctl = '0;
		unique case (phase_q)
			PH_HUNT:     ctl = '0;
			PH_SYNC2:    ctl.crc_init = (rx_byte == SYNC_SECOND);
			PH_VERSION: begin
				ctl.cap_version = 1'b1;
				ctl.crc_en      = 1'b1;
			end
			PH_MESSAGE: begin
				ctl.cap_message = 1'b1;
				ctl.crc_en      = 1'b1;
			end
			PH_SEQUENCE: begin
				ctl.cap_sequence = 1'b1;
				ctl.crc_en       = 1'b1;
			end
			PH_LENGTH: begin
				ctl.crc_en     = 1'b1;
				ctl.fill_clr   = 1'b1;
				ctl.cap_length = !len_over;
			end
			PH_PAYLOAD: begin
				ctl.ram_we = !fill_full;
				ctl.crc_en = !fill_full;
			end
			PH_CRC_LO:   ctl.cap_crc_lo = 1'b1;
			PH_CRC_HI:   ctl.frame_done = 1'b1;
			default:     ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			version_q  <= '0;
			message_q  <= '0;
			sequence_q <= '0;
			length_q   <= '0;
			fill_q     <= '0;
			crc_lo_q   <= '0;
			crc_q      <= CRC_INIT;
		end else if (rx_take) begin
			phase_q <= phase_d;
			if (ctl.crc_init) begin
				crc_q <= CRC_INIT;
			end else if (ctl.crc_en) begin
				crc_q <= crc16_update(crc_q, rx_byte);
			end
			if (ctl.cap_version) begin
				version_q <= rx_byte;
			end
			if (ctl.cap_message) begin
				message_q <= rx_byte;
			end
			if (ctl.cap_sequence) begin
				sequence_q <= rx_byte;
			end
			if (ctl.cap_length) begin
				length_q <= rx_byte[LEN_W-1:0];
			end
			if (ctl.fill_clr) begin
				fill_q <= '0;
			end else if (ctl.ram_we) begin
				fill_q <= fill_inc[LEN_W-1:0];
			end
			if (ctl.cap_crc_lo) begin
				crc_lo_q <= rx_byte;
			end
		end
	end

	// Readout sequencer: walks the payload RAM once per finished frame.
	assign issue    = emit_active_q && (!res_valid_q || !result_stall);
	assign emit_inc = {1'b0, emit_idx_q} + 1'b1;
	assign issue_last = emit_zero_q || (emit_inc >= {1'b0, length_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_active_q <= 1'b0;
			emit_reject_q <= 1'b0;
			emit_zero_q   <= 1'b0;
			emit_idx_q    <= '0;
		end else if (rx_take && ctl.frame_done) begin
			emit_active_q <= 1'b1;
			emit_reject_q <= !frame_good;
			emit_zero_q   <= !frame_good || (length_q == '0);
			emit_idx_q    <= '0;
		end else if (issue) begin
			emit_idx_q <= emit_inc[LEN_W-1:0];
			if (issue_last) begin
				emit_active_q <= 1'b0;
			end
		end
	end

	// Result register; the payload byte itself is the RAM's read register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (issue) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			res_status_q <= emit_reject_q;
			res_zero_q   <= emit_zero_q;
			res_last_q   <= issue_last;
			res_pos_q    <= emit_idx_q[IDX_W-1:0];
			res_msg_q    <= message_q;
			res_seq_q    <= sequence_q;
			res_len_q    <= length_q;
		end
	end

	sfr_payload_ram #(
		.DEPTH  (MAX_PAYLOAD_BYTES),
		.ADDR_W (IDX_W)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (rx_take && ctl.ram_we),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (rx_byte),
		.rd_en   (issue),
		.rd_addr (emit_idx_q[IDX_W-1:0]),
		.rd_data (ram_rd_data)
	);

	assign len_ext = 8'(res_len_q);
	assign pos_ext = 8'(res_pos_q);

	assign result_valid    = res_valid_q;
	assign message_type    = res_msg_q;
	assign sequence_number = res_seq_q;
	assign payload_length  = len_ext[6:0];
	assign frame_status    = res_status_q;
	assign payload_byte    = res_zero_q ? 8'h00 : ram_rd_data;
	assign byte_position   = pos_ext[5:0];
	assign last_of_frame   = res_last_q;

	// The RAM is never written while the same frame is being read out.
	`SFR_ASSERT(a_no_write_in_readout, !(rx_take && ctl.ram_we && emit_active_q), "payload write during readout")
	// A finished frame always starts a readout on the next cycle.
	`SFR_ASSERT(a_done_starts_readout, (rx_take && ctl.frame_done) |=> emit_active_q, "frame end without readout")
	// Issuing the last result ends the readout.
	`SFR_ASSERT(a_last_ends_readout, (issue && issue_last) |=> !emit_active_q, "readout runs past last result")
	// A rejected or empty frame gives exactly one result, marked last.
	`SFR_ASSERT(a_zero_is_single, (issue && emit_zero_q) |-> (issue_last && (emit_idx_q == '0)), "single result broken")

endmodule

@@ rtl/sfr_payload_ram.sv @@
// Payload store: one write port and one registered read port.
`timescale 1ns / 1ps
module sfr_payload_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// The read data holds until the next read, so it can serve as an output register.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
